### rtl/cd_position_subq_generator_defines.svh
// Assertion macros for the CD position and subchannel-Q unit.
`ifndef CD_POSITION_SUBQ_GENERATOR_DEFINES_SVH
`define CD_POSITION_SUBQ_GENERATOR_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define CDPS_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset
`define CDPS_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CDPS_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg)
`define CDPS_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg)
`endif

`endif

### rtl/cdps_pkg.sv
// Shared types, constants and helper functions for the CD position unit.
package cdps_pkg;

    localparam int unsigned POS_W           = 19;
    localparam int unsigned PREGAP_DEFAULT  = 150;
    localparam int unsigned SECTORS_PER_MIN = 60 * 75;
    localparam int unsigned SECTORS_PER_SEC = 75;

    // Command codes
    localparam logic [2:0] ACT_RESET       = 3'd0;
    localparam logic [2:0] ACT_GOTO_START  = 3'd1;
    localparam logic [2:0] ACT_SEEK        = 3'd2;
    localparam logic [2:0] ACT_READ_HEADER = 3'd3;
    localparam logic [2:0] ACT_READ_Q      = 3'd4;
    localparam logic [2:0] ACT_LEADIN      = 3'd5;
    localparam logic [2:0] ACT_TELL        = 3'd6;

    // Only track / session 1 exists on the image
    localparam logic [6:0] UNIT_FIRST = 7'd1;

    // Fixed Q bytes: control/ADR and track number
    localparam logic [7:0] Q_CTRL_ADR = 8'h41;
    localparam logic [7:0] Q_TRACK_NO = 8'h01;
    localparam logic [7:0] Q_ZERO     = 8'h00;

    typedef struct packed {
        logic [2:0] action;
        logic [6:0] target_min;
        logic [5:0] target_sec;
        logic [6:0] target_frame;
        logic [6:0] unit_number;
        logic       advance;
    } cmd_t;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] position;
        logic             index_flag;
        logic             has_data;
        logic [7:0]       abs_min_bcd;
        logic [6:0]       abs_sec_bcd;
        logic [6:0]       abs_frame_bcd;
        logic [7:0]       rel_min_bcd;
        logic [6:0]       rel_sec_bcd;
        logic [6:0]       rel_frame_bcd;
        logic [15:0]      q_crc;
    } res_t;

    typedef struct packed {
        logic [7:0] min_bcd;
        logic [6:0] sec_bcd;
        logic [6:0] frame_bcd;
    } msf_t;

    // Binary to packed BCD for values below 128; tens via multiply by 205/2048
    function automatic logic [7:0] to_bcd(input logic [6:0] n);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(n) * 15'd205;
        tens = prod[14:11];
        ones = n - 7'(tens) * 7'd10;
        return {tens, ones[3:0]};
    endfunction

    // CRC-16-CCITT, poly 0x1021, MSB first, one byte (flattens to an XOR net)
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

    // CRC state after the two constant leading Q bytes
    localparam logic [15:0] Q_CRC_SEED = crc_byte(crc_byte(16'h0000, Q_CTRL_ADR), Q_TRACK_NO);

endpackage

### rtl/cdps_cmd_if.sv
// Command channel: valid/ready with one command item as payload.
interface cdps_cmd_if;
    import cdps_pkg::*;

    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/cdps_res_if.sv
// Result channel: valid/ready with one result item as payload.
interface cdps_res_if;
    import cdps_pkg::*;

    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/cd_position_subq_generator.sv
// Top level: CD head position unit with subchannel-Q and header reporting.
//
//  channel | role       | transfer contents
//  --------+------------+------------------------------------------------
//  cmd     | sink       | action, seek MSF, unit number, advance
//  res     | source     | ok, position, index, header flag, BCD MSF, Q CRC
//  cfg     | write only | disc_sectors (cfg_we / cfg_wdata)
//
// Each command is held in the command register, is executed in one
// pass through the address and CRC logic and lands in the result register;
// a new command is taken every cycle while the result side is not stalled.
// The position register updates on the same edge the result is loaded.
// A stalled result only blocks new commands once the command register is
// also full. Reset puts the head on the first track sector.
`include "cd_position_subq_generator_defines.svh"

module cd_position_subq_generator #(
    parameter int unsigned PREGAP_SECTORS = cdps_pkg::PREGAP_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cdps_pkg::POS_W-1:0] cfg_wdata,
    cdps_cmd_if.sink                   cmd,
    cdps_res_if.source                 res
);
    import cdps_pkg::*;

    localparam logic [POS_W-1:0] PREGAP_POS = POS_W'(PREGAP_SECTORS);
    localparam int unsigned      SEEK_W     = POS_W + 1;

    // Registers
    logic [POS_W-1:0] disc_sectors_reg, disc_sectors_next;
    logic [POS_W-1:0] cur_sector_reg, cur_sector_next;
    logic             s1_valid_reg, s1_valid_next;
    cmd_t             s1_cmd_reg;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg;

    // Datapath
    logic             res_load;
    logic             cmd_take;
    logic [POS_W:0]   end_sum;
    logic [POS_W-1:0] end_pos;
    logic [POS_W-1:0] s;
    logic             s_in_range;
    logic             s_in_data;
    logic [SEEK_W-1:0] seek_pos;
    logic             seek_ok;
    logic [POS_W-1:0] rel;
    msf_t             abs_msf;
    msf_t             rel_msf;
    logic [7:0]       q_bytes [8];
    logic [15:0]      crc;
    logic [POS_W-1:0] cur_new;
    logic [POS_W-1:0] idx_sector;
    logic             is_read;
    res_t             res_new;

    // Handshake
    assign res_load  = s1_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !s1_valid_reg || res_load;
    assign cmd_take  = cmd.valid && cmd.ready;
    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

    // End of disc, saturated to the position range
    always_comb
    begin
        end_sum = {1'b0, disc_sectors_reg} + {1'b0, PREGAP_POS};
        end_pos = end_sum[POS_W] ? '1 : end_sum[POS_W-1:0];
    end

    assign s          = cur_sector_reg;
    assign s_in_range = s < end_pos;
    assign s_in_data  = s >= PREGAP_POS;

    // Seek target in sectors
    always_comb
    begin
        seek_pos = SEEK_W'(s1_cmd_reg.target_min) * SEEK_W'(SECTORS_PER_MIN)
                 + SEEK_W'(s1_cmd_reg.target_sec) * SEEK_W'(SECTORS_PER_SEC)
                 + SEEK_W'(s1_cmd_reg.target_frame);
        seek_ok  = seek_pos < {1'b0, end_pos};
    end

    // Track relative sector, counting down in the pregap
    assign rel = s_in_data ? (s - PREGAP_POS) : (PREGAP_POS - POS_W'(1) - s);

    cdps_msf u_abs_msf (
        .sector (s),
        .msf    (abs_msf)
    );

    cdps_msf u_rel_msf (
        .sector (rel),
        .msf    (rel_msf)
    );

    // Q CRC over the variable bytes, seeded past the constant head
    always_comb
    begin
        q_bytes[0] = 8'(s_in_data);
        q_bytes[1] = rel_msf.min_bcd;
        q_bytes[2] = 8'(rel_msf.sec_bcd);
        q_bytes[3] = 8'(rel_msf.frame_bcd);
        q_bytes[4] = Q_ZERO;
        q_bytes[5] = abs_msf.min_bcd;
        q_bytes[6] = 8'(abs_msf.sec_bcd);
        q_bytes[7] = 8'(abs_msf.frame_bcd);
        crc = Q_CRC_SEED;
        for (int i = 0; i < 8; i++) begin
            crc = crc_byte(crc, q_bytes[i]);
        end
    end

    // Command execution
    always_comb
    begin
        cur_new = s;
        res_new = '0;
        unique case (s1_cmd_reg.action)
            ACT_RESET, ACT_LEADIN:
            begin
                cur_new    = '0;
                res_new.ok = 1'b1;
            end
            ACT_GOTO_START:
            begin
                if (s1_cmd_reg.unit_number == UNIT_FIRST)
                begin
                    cur_new    = PREGAP_POS;
                    res_new.ok = 1'b1;
                end
            end
            ACT_SEEK:
            begin
                if (seek_ok)
                begin
                    cur_new    = seek_pos[POS_W-1:0];
                    res_new.ok = 1'b1;
                end
            end
            ACT_READ_HEADER:
            begin
                if (s_in_range)
                begin
                    res_new.ok = 1'b1;
                    if (s_in_data)
                    begin
                        res_new.has_data      = 1'b1;
                        res_new.abs_min_bcd   = abs_msf.min_bcd;
                        res_new.abs_sec_bcd   = abs_msf.sec_bcd;
                        res_new.abs_frame_bcd = abs_msf.frame_bcd;
                    end
                    if (s1_cmd_reg.advance)
                        cur_new = s + POS_W'(1);
                end
            end
            ACT_READ_Q:
            begin
                if (s_in_range)
                begin
                    res_new.ok            = 1'b1;
                    res_new.abs_min_bcd   = abs_msf.min_bcd;
                    res_new.abs_sec_bcd   = abs_msf.sec_bcd;
                    res_new.abs_frame_bcd = abs_msf.frame_bcd;
                    res_new.rel_min_bcd   = rel_msf.min_bcd;
                    res_new.rel_sec_bcd   = rel_msf.sec_bcd;
                    res_new.rel_frame_bcd = rel_msf.frame_bcd;
                    res_new.q_crc         = ~crc;
                    if (s1_cmd_reg.advance)
                        cur_new = s + POS_W'(1);
                end
            end
            ACT_TELL:
            begin
                res_new.ok            = 1'b1;
                res_new.abs_min_bcd   = abs_msf.min_bcd;
                res_new.abs_sec_bcd   = abs_msf.sec_bcd;
                res_new.abs_frame_bcd = abs_msf.frame_bcd;
            end
            default:
            begin
            end
        endcase

        // Index reports the sector read, else the new position
        // (a failed read leaves the position on the same sector)
        is_read            = (s1_cmd_reg.action == ACT_READ_HEADER) ||
                             (s1_cmd_reg.action == ACT_READ_Q);
        idx_sector         = is_read ? s : cur_new;
        res_new.index_flag = (idx_sector >= PREGAP_POS) && (idx_sector < end_pos);
        res_new.position   = cur_new;
    end

    // Next-state logic
    always_comb
    begin
        disc_sectors_next = cfg_we ? cfg_wdata : disc_sectors_reg;
        cur_sector_next   = res_load ? cur_new : cur_sector_reg;
        s1_valid_next     = cmd_take ? 1'b1 : (res_load ? 1'b0 : s1_valid_reg);
        res_valid_next    = res_load ? 1'b1 : (res.ready ? 1'b0 : res_valid_reg);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disc_sectors_reg <= '0;
            cur_sector_reg   <= PREGAP_POS;
            s1_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            disc_sectors_reg <= disc_sectors_next;
            cur_sector_reg   <= cur_sector_next;
            s1_valid_reg     <= s1_valid_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_take)
            s1_cmd_reg <= cmd.data;
        if (res_load)
            res_reg <= res_new;
    end

    // Checks
    `CDPS_ASSERT_NXT(a_pos_matches_state, clk, rst_n, res_load, res_reg.position == cur_sector_reg, "reported position differs from head position")
    `CDPS_ASSERT_IMP(a_ready_only_when_blocked, clk, rst_n, !cmd.ready, s1_valid_reg && res_valid_reg && !res.ready, "command side stalled without a full pipe")
    `CDPS_ASSERT_IMP(a_data_in_track, clk, rst_n, res_valid_reg && res_reg.has_data, res_reg.ok && res_reg.index_flag, "header data flagged outside the track area")

endmodule

### rtl/cdps_msf.sv
// Sector number to BCD minute/second/frame converter (combinational).
module cdps_msf (
    input  logic [cdps_pkg::POS_W-1:0] sector,
    output cdps_pkg::msf_t             msf
);
    import cdps_pkg::*;

    // Reciprocals, exact for any 19-bit sector
    localparam int unsigned     MIN_SHIFT = 32;
    localparam longint unsigned MIN_RECIP =
        ((64'd1 << MIN_SHIFT) + SECTORS_PER_MIN - 1) / SECTORS_PER_MIN;
    localparam int unsigned     SEC_SHIFT = 16;
    localparam longint unsigned SEC_RECIP =
        ((64'd1 << SEC_SHIFT) + SECTORS_PER_SEC - 1) / SECTORS_PER_SEC;

    localparam int unsigned MIN_PROD_W = POS_W + 20;
    localparam int unsigned SEC_PROD_W = 13 + 10;

    logic [MIN_PROD_W-1:0] min_prod;
    logic [6:0]            minutes;
    logic [12:0]           rem;
    logic [SEC_PROD_W-1:0] sec_prod;
    logic [6:0]            seconds;
    logic [6:0]            frames;

    // Minutes, then remainder within the minute
    always_comb
    begin
        min_prod = MIN_PROD_W'(sector) * MIN_PROD_W'(MIN_RECIP);
        minutes  = min_prod[MIN_SHIFT +: 7];
        rem      = 13'(sector - POS_W'(minutes) * POS_W'(SECTORS_PER_MIN));
        sec_prod = SEC_PROD_W'(rem) * SEC_PROD_W'(SEC_RECIP);
        seconds  = sec_prod[SEC_SHIFT +: 7];
        frames   = 7'(rem - 13'(seconds) * 13'(SECTORS_PER_SEC));
    end

    // BCD packing; sec and frame stay below 0x75
    always_comb
    begin
        msf.min_bcd   = to_bcd(minutes);
        msf.sec_bcd   = 7'(to_bcd(seconds));
        msf.frame_bcd = 7'(to_bcd(frames));
    end

endmodule

### dv/cd_position_subq_generator_tb.sv
// Self-checking testbench for the CD head position and subchannel-Q unit.
module cd_position_subq_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdps_pkg::*;

    localparam int unsigned CLK_PERIOD     = 8;
    localparam int unsigned PREGAP         = PREGAP_DEFAULT;
    localparam int unsigned POS_MAX        = (1 << POS_W) - 1;
    localparam int unsigned DISC_MAX_LEGAL = 449849;
    localparam int unsigned LAT_CYCLES     = 4;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES    = 64;
    localparam int unsigned N_PHASES       = 6;
    localparam int unsigned PHASE_ITEMS    = 225;
    localparam int unsigned MAX_REPORTS    = 60;

    // Action code the block leaves unused
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    typedef struct {
        cmd_t cmd;
        bit   typed;
        res_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [POS_W-1:0] cfg_wdata;

    cdps_cmd_if cmd_ch ();
    cdps_res_if res_ch ();

    cd_position_subq_generator #(
        .PREGAP_SECTORS(PREGAP)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .cmd      (cmd_ch),
        .res      (res_ch)
    );

    // Predictor state: head position and programmed disc size
    int unsigned head_sector;
    int unsigned disc_count;

    res_t        exp_results[$];
    dir_row_t    dir_rows[$];
    int unsigned err_count;
    int unsigned n_results;
    int unsigned quiet_cycles;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    bit          hold_req;

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic int unsigned disc_end();
        int unsigned e;
        e = disc_count + PREGAP;
        return (e > POS_MAX) ? POS_MAX : e;
    endfunction

    function automatic bit in_data_area(input int unsigned s);
        return (s >= PREGAP) && (s < disc_end());
    endfunction

    function automatic logic [7:0] bcd_byte(input int unsigned n);
        return 8'((n / 10) * 16 + n % 10);
    endfunction

    function automatic msf_t msf_of(input int unsigned s);
        msf_t        m;
        int unsigned rem;
        rem         = s % SECTORS_PER_MIN;
        m.min_bcd   = bcd_byte(s / SECTORS_PER_MIN);
        m.sec_bcd   = 7'(bcd_byte(rem / SECTORS_PER_SEC));
        m.frame_bcd = 7'(bcd_byte(rem % SECTORS_PER_SEC));
        return m;
    endfunction

    // CCITT polynomial, MSB first, bit-serial form
    function automatic logic [15:0] crc16_ccitt(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ 16'h1021;
        end
        return c;
    endfunction

    // Expected result of one command; moves the predicted head
    function automatic res_t predict_cmd(input cmd_t c);
        res_t        r;
        int unsigned s;
        int unsigned tgt;
        int unsigned rel;
        msf_t        abs_m;
        msf_t        rel_m;
        logic [7:0]  q_bytes [10];
        logic [15:0] crc;
        r = '0;
        s = head_sector;
        case (c.action)
            ACT_RESET, ACT_LEADIN:
            begin
                head_sector = 0;
                r.ok        = 1'b1;
            end
            ACT_GOTO_START:
            begin
                if (c.unit_number == UNIT_FIRST)
                begin
                    head_sector = PREGAP;
                    r.ok        = 1'b1;
                end
            end
            ACT_SEEK:
            begin
                // no per-field range check, only the total against the end
                tgt = c.target_min * SECTORS_PER_MIN + c.target_sec * SECTORS_PER_SEC
                      + c.target_frame;
                if (tgt < disc_end())
                begin
                    head_sector = tgt;
                    r.ok        = 1'b1;
                end
            end
            ACT_READ_HEADER:
            begin
                if (s < disc_end())
                begin
                    r.ok = 1'b1;
                    // pregap headers are zero filled
                    if (s >= PREGAP)
                    begin
                        r.has_data = 1'b1;
                        {r.abs_min_bcd, r.abs_sec_bcd, r.abs_frame_bcd} = msf_of(s);
                    end
                    if (c.advance)
                        head_sector = s + 1;
                end
            end
            ACT_READ_Q:
            begin
                if (s < disc_end())
                begin
                    r.ok  = 1'b1;
                    // relative time counts down through the pregap
                    rel   = (s >= PREGAP) ? (s - PREGAP) : (PREGAP - 1 - s);
                    rel_m = msf_of(rel);
                    abs_m = msf_of(s);
                    {r.rel_min_bcd, r.rel_sec_bcd, r.rel_frame_bcd} = rel_m;
                    {r.abs_min_bcd, r.abs_sec_bcd, r.abs_frame_bcd} = abs_m;
                    q_bytes = '{Q_CTRL_ADR, Q_TRACK_NO, {7'd0, (s >= PREGAP)},
                                rel_m.min_bcd, {1'b0, rel_m.sec_bcd}, {1'b0, rel_m.frame_bcd},
                                Q_ZERO,
                                abs_m.min_bcd, {1'b0, abs_m.sec_bcd}, {1'b0, abs_m.frame_bcd}};
                    crc = 16'h0000;
                    foreach (q_bytes[i])
                        crc = crc16_ccitt(crc, q_bytes[i]);
                    r.q_crc = ~crc;
                    if (c.advance)
                        head_sector = s + 1;
                end
            end
            ACT_TELL:
            begin
                r.ok = 1'b1;
                {r.abs_min_bcd, r.abs_sec_bcd, r.abs_frame_bcd} = msf_of(s);
            end
            default:
            begin
            end
        endcase
        r.position = POS_W'(head_sector);
        // reads report the index of the sector read, others of the new position
        if (r.ok && (c.action == ACT_READ_HEADER || c.action == ACT_READ_Q))
            r.index_flag = in_data_area(s);
        else
            r.index_flag = in_data_area(head_sector);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic cmd_t mk_cmd(input logic [2:0] act, input int unsigned mins,
                                    input int unsigned secs, input int unsigned frms,
                                    input int unsigned unit, input bit adv);
        cmd_t c;
        c.action       = act;
        c.target_min   = 7'(mins);
        c.target_sec   = 6'(secs);
        c.target_frame = 7'(frms);
        c.unit_number  = 7'(unit);
        c.advance      = adv;
        return c;
    endfunction

    function automatic res_t mk_res(input bit ok, input int unsigned pos, input bit idx,
                                    input bit hasd, input logic [7:0] a_min,
                                    input logic [6:0] a_sec, input logic [6:0] a_frm);
        res_t r;
        r               = '0;
        r.ok            = ok;
        r.position      = POS_W'(pos);
        r.index_flag    = idx;
        r.has_data      = hasd;
        r.abs_min_bcd   = a_min;
        r.abs_sec_bcd   = a_sec;
        r.abs_frame_bcd = a_frm;
        return r;
    endfunction

    // Seek target biased to the disc start, the pregap edge and the end
    function automatic int unsigned pick_target();
        int unsigned last;
        last = disc_end();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 3);
            1:       return PREGAP - 2 + $urandom_range(0, 3);
            2, 3:    return last - 3 + $urandom_range(0, 4);
            4:       return $urandom_range(0, last - 1);
            5:       return $urandom_range(0, POS_MAX);
            default: return $urandom_range(0, last + 10);
        endcase
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t        c;
        int unsigned pick;
        int unsigned tgt;
        // every field random first, then shaped by the chosen command
        c = mk_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 127), $urandom_range(0, 63),
                   $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return c;
        c.advance = ($urandom_range(0, 3) != 0);
        if (pick < 34)
        begin
            tgt            = pick_target();
            c.action       = ACT_SEEK;
            c.target_min   = 7'(tgt / SECTORS_PER_MIN);
            c.target_sec   = 6'((tgt % SECTORS_PER_MIN) / SECTORS_PER_SEC);
            c.target_frame = 7'(tgt % SECTORS_PER_SEC);
            // same sector with the frame field past its usual range
            if ($urandom_range(0, 7) == 0 && c.target_sec != 0 && c.target_frame <= 52)
            begin
                c.target_sec   = c.target_sec - 1;
                c.target_frame = c.target_frame + 75;
            end
        end
        else if (pick < 56)
            c.action = ACT_READ_HEADER;
        else if (pick < 80)
            c.action = ACT_READ_Q;
        else if (pick < 88)
            c.action = ACT_TELL;
        else if (pick < 95)
        begin
            c.action = ACT_GOTO_START;
            if ($urandom_range(0, 3) != 0)
                c.unit_number = UNIT_FIRST;
        end
        else
            c.action = ($urandom_range(0, 1) != 0) ? ACT_RESET : ACT_LEADIN;
        return c;
    endfunction

    function automatic int unsigned phase_disc(input int unsigned p);
        case (p)
            0:       return 0;
            1:       return DISC_MAX_LEGAL;
            2:       return POS_MAX;
            3:       return $urandom_range(1, 3000);
            4:       return $urandom_range(0, POS_MAX);
            default: return $urandom_range(0, 600);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH result %0d: %s", $time, n_results, msg);
    endtask

    task automatic cmp_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic check_result(input res_t got);
        res_t want;
        if (exp_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected transfer %h", got));
            return;
        end
        want = exp_results.pop_front();
        cmp_field("ok", got.ok, want.ok);
        cmp_field("position", got.position, want.position);
        cmp_field("index_flag", got.index_flag, want.index_flag);
        cmp_field("has_data", got.has_data, want.has_data);
        cmp_field("abs_min_bcd", got.abs_min_bcd, want.abs_min_bcd);
        cmp_field("abs_sec_bcd", got.abs_sec_bcd, want.abs_sec_bcd);
        cmp_field("abs_frame_bcd", got.abs_frame_bcd, want.abs_frame_bcd);
        cmp_field("rel_min_bcd", got.rel_min_bcd, want.rel_min_bcd);
        cmp_field("rel_sec_bcd", got.rel_sec_bcd, want.rel_sec_bcd);
        cmp_field("rel_frame_bcd", got.rel_frame_bcd, want.rel_frame_bcd);
        cmp_field("q_crc", got.q_crc, want.q_crc);
        n_results++;
    endtask

    // ---------------------------------------------------------------
    // Command side
    // ---------------------------------------------------------------

    // Offer one command and log its expected result once transferred
    task automatic issue_cmd(input cmd_t c, input bit typed, input res_t want);
        res_t pred;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        pred = predict_cmd(c);
        exp_results.push_back(typed ? want : pred);
    endtask

    // Drain everything in flight so the block is idle
    task automatic drain_block();
        cmd_ch.valid <= 1'b0;
        while (exp_results.size() != 0)
            @(posedge clk);
        repeat (LAT_CYCLES) @(posedge clk);
    endtask

    task automatic write_disc(input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_wdata <= POS_W'(value);
        @(posedge clk);
        cfg_we     <= 1'b0;
        disc_count = value & POS_MAX;
    endtask

    // ---------------------------------------------------------------
    // Result side: random back-pressure plus one long hold on request
    // ---------------------------------------------------------------
    initial
    begin : result_drain
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                check_result(res_ch.data);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Watchdog: cycles without any transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1)
            || (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("cd_position_subq_generator_tb NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        head_sector  = PREGAP;
        disc_count   = 0;
        err_count    = 0;
        n_results    = 0;
        quiet_cycles = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, 1000 data sectors: data area is 150..1149
        write_disc(1000);
        dir_rows.push_back('{mk_cmd(ACT_TELL, 0, 0, 0, 0, 0), 1'b1,
                             mk_res(1, 150, 1, 0, 8'h00, 7'h02, 7'h00)});
        dir_rows.push_back('{mk_cmd(ACT_READ_HEADER, 0, 0, 0, 0, 0), 1'b1,
                             mk_res(1, 150, 1, 1, 8'h00, 7'h02, 7'h00)});
        dir_rows.push_back('{mk_cmd(ACT_READ_Q, 0, 0, 0, 0, 1), 1'b0, '0});
        dir_rows.push_back('{mk_cmd(ACT_GOTO_START, 0, 0, 0, 0, 0), 1'b1,
                             mk_res(0, 151, 1, 0, 8'h00, 7'h00, 7'h00)});
        dir_rows.push_back('{mk_cmd(ACT_GOTO_START, 127, 63, 127, 127, 1), 1'b0, '0});
        dir_rows.push_back('{mk_cmd(ACT_GOTO_START, 0, 0, 0, 1, 0), 1'b1,
                             mk_res(1, 150, 1, 0, 8'h00, 7'h00, 7'h00)});
        dir_rows.push_back('{mk_cmd(ACT_RESET, 0, 0, 0, 0, 0), 1'b1,
                             mk_res(1, 0, 0, 0, 8'h00, 7'h00, 7'h00)});
        // zero-filled pregap header
        dir_rows.push_back('{mk_cmd(ACT_READ_HEADER, 0, 0, 0, 0, 1), 1'b1,
                             mk_res(1, 1, 0, 0, 8'h00, 7'h00, 7'h00)});
        dir_rows.push_back('{mk_cmd(ACT_READ_Q, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_cmd(ACT_SEEK, 0, 1, 74, 0, 0), 1'b1,
                             mk_res(1, 149, 0, 0, 8'h00, 7'h00, 7'h00)});
        dir_rows.push_back('{mk_cmd(ACT_READ_Q, 0, 0, 0, 0, 1), 1'b0, '0});
        dir_rows.push_back('{mk_cmd(ACT_READ_Q, 0, 0, 0, 0, 0), 1'b0, '0});
        // last data sector, then past the end
        dir_rows.push_back('{mk_cmd(ACT_SEEK, 0, 15, 24, 0, 0), 1'b1,
                             mk_res(1, 1149, 1, 0, 8'h00, 7'h00, 7'h00)});
        dir_rows.push_back('{mk_cmd(ACT_READ_HEADER, 0, 0, 0, 0, 1), 1'b1,
                             mk_res(1, 1150, 1, 1, 8'h00, 7'h15, 7'h24)});
        dir_rows.push_back('{mk_cmd(ACT_READ_HEADER, 0, 0, 0, 0, 1), 1'b1,
                             mk_res(0, 1150, 0, 0, 8'h00, 7'h00, 7'h00)});
        dir_rows.push_back('{mk_cmd(ACT_READ_Q, 0, 0, 0, 0, 1), 1'b0, '0});
        dir_rows.push_back('{mk_cmd(ACT_TELL, 0, 0, 0, 0, 0), 1'b0, '0});
        // seeks at and beyond the end, and seeks with fields above their usual range
        dir_rows.push_back('{mk_cmd(ACT_SEEK, 0, 15, 25, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_cmd(ACT_SEEK, 127, 63, 127, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_cmd(ACT_SEEK, 0, 63, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_cmd(ACT_SEEK, 0, 0, 127, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_cmd(ACT_LEADIN, 0, 0, 0, 0, 0), 1'b1,
                             mk_res(1, 0, 0, 0, 8'h00, 7'h00, 7'h00)});
        dir_rows.push_back('{mk_cmd(ACT_UNUSED, 99, 59, 74, 1, 1), 1'b1,
                             mk_res(0, 0, 0, 0, 8'h00, 7'h00, 7'h00)});
        dir_rows.push_back('{mk_cmd(ACT_SEEK, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_cmd(ACT_READ_Q, 0, 0, 0, 0, 1), 1'b0, '0});
        foreach (dir_rows[i])
            issue_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
        drain_block();

        // Random phases, each with its own disc size and one of three idling patterns
        for (int unsigned p = 0; p < N_PHASES; p++)
        begin
            if (p < 2)
            begin
                src_idle_pct = 7;
                snk_idle_pct = 79;
            end
            else if (p < 4)
            begin
                src_idle_pct = 79;
                snk_idle_pct = 7;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            write_disc(phase_disc(p));
            // long receiver stall while commands keep coming
            if (p == 0 || p == 4)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS) issue_cmd(rand_cmd(), 1'b0, '0);
            drain_block();
        end

        if (exp_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", exp_results.size()));
        if (err_count == 0)
            $display("cd_position_subq_generator_tb OK");
        else
            $display("cd_position_subq_generator_tb NOT OK");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/cdps_pkg.sv
rtl/cdps_cmd_if.sv
rtl/cdps_res_if.sv
rtl/cdps_msf.sv
rtl/cd_position_subq_generator.sv
dv/cd_position_subq_generator_tb.sv
